// ===== rtl/vrt_pkg.sv =====
package vrt_pkg;

    // Fixed field widths.
    localparam int DIR_W  = 32;
    localparam int ID_W   = 8;
    localparam int VOX_W  = 16;
    localparam int FACE_W = 2;
    localparam int STAT_W = 2;

    // Ray distances are unsigned Q16.32.
    localparam int T_W    = 48;
    localparam int T_FRAC = 32;
    localparam logic [T_W-1:0] T_MAX   = {T_W{1'b1}};
    localparam logic [T_W-1:0] T_LIMIT = T_W'(1) << T_FRAC;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_QUERY = 2'd0;
    localparam logic [STAT_W-1:0] ST_HIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;

    // Input actions.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BLOCK = 1'b1;

    // Configuration register indexes.
    localparam logic REG_PASS_A = 1'b0;
    localparam logic REG_PASS_B = 1'b1;

    // Division job kinds.
    localparam logic KIND_NEXT    = 1'b0;
    localparam logic KIND_SPACING = 1'b1;

    typedef struct packed {
        logic              start_load;
        logic              div_start;
        logic              div_store;
        logic [1:0]        axis;
        logic              kind;
        logic              sel;
        logic              advance;
        logic              clear_active;
        logic              load_out;
        logic [STAT_W-1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic solid;
        logic beyond;
        logic div_done;
    } t_sts;

endpackage

// ===== rtl/voxel_ray_traversal.sv =====
// Channel  | handshake                      | payload
// ---------+--------------------------------+-----------------------------------------
// input    | i_in_valid / o_in_stall        | i_action, i_origin_*, i_dir_*, i_block_id
// output   | o_out_valid / i_out_stall      | o_status, o_voxel_*, o_face_*
// config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// A block-id transaction on an active ray that is not solid passes through accept, axis
// advance and result write; one that hits or arrives with no ray active goes straight to result write.
// A start transaction runs six divisions on one shared bit-serial divider.
// Reset is synchronous and returns the unit to idle with the passable ids at 8 and 10.
// A finished result waits in the output register while the next transaction is taken;
// a further result waits in the controller until the output register is free.
module voxel_ray_traversal #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_origin_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_origin_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_origin_z,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_dir_x,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_dir_y,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_dir_z,
    input  logic [vrt_pkg::ID_W-1:0]            i_block_id,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [vrt_pkg::STAT_W-1:0]          o_status,
    output logic signed [vrt_pkg::VOX_W-1:0]    o_voxel_x,
    output logic signed [vrt_pkg::VOX_W-1:0]    o_voxel_y,
    output logic signed [vrt_pkg::VOX_W-1:0]    o_voxel_z,
    output logic signed [vrt_pkg::FACE_W-1:0]   o_face_x,
    output logic signed [vrt_pkg::FACE_W-1:0]   o_face_y,
    output logic signed [vrt_pkg::FACE_W-1:0]   o_face_z,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import vrt_pkg::*;

    logic [ID_W-1:0]          r_pass_a;
    logic [ID_W-1:0]          r_pass_b;
    logic                     cfg_wr;
    t_cmd                     cmd;
    t_sts                     sts;
    logic signed [DIR_W-1:0]  origin [3];
    logic signed [DIR_W-1:0]  dir    [3];
    logic signed [VOX_W-1:0]  voxel  [3];
    logic signed [FACE_W-1:0] face   [3];

    // Configuration registers; byte address bits below the word are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_a <= 8'd8;
            r_pass_b <= 8'd10;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PASS_A) begin
                r_pass_a <= pwdata[ID_W-1:0];
            end else begin
                r_pass_b <= pwdata[ID_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_PASS_B) ? 32'(r_pass_b) : 32'(r_pass_a);

    assign origin = '{i_origin_x, i_origin_y, i_origin_z};
    assign dir    = '{i_dir_x, i_dir_y, i_dir_z};

    vrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    vrt_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_pass_a   (r_pass_a),
        .i_pass_b   (r_pass_b),
        .i_origin   (origin),
        .i_dir      (dir),
        .i_block_id (i_block_id),
        .o_status   (o_status),
        .o_voxel    (voxel),
        .o_face     (face)
    );

    assign o_voxel_x = voxel[0];
    assign o_voxel_y = voxel[1];
    assign o_voxel_z = voxel[2];
    assign o_face_x  = face[0];
    assign o_face_y  = face[1];
    assign o_face_z  = face[2];

    // A start transaction never produces its result in the following cycle.
    a_start_not_immediate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_action == ACT_START) |=> !$rose(o_out_valid))
        else $error("start result appeared before the divisions finished");

    // A miss carries no voxel and no face.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_MISS) |->
        (o_voxel_x == '0 && o_voxel_y == '0 && o_voxel_z == '0 &&
         o_face_x == '0 && o_face_y == '0 && o_face_z == '0))
        else $error("miss result with non-zero fields");

    // A query carries no entry face.
    a_query_no_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_QUERY) |->
        (o_face_x == '0 && o_face_y == '0 && o_face_z == '0))
        else $error("query result with an entry face");

    // A hit has at most one face component set.
    a_hit_one_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_HIT) |->
        ($countones({o_face_x != '0, o_face_y != '0, o_face_z != '0}) <= 1))
        else $error("hit result with more than one face component");

endmodule

// ===== rtl/vrt_div.sv =====
module vrt_div #(
    parameter int NUM_W = 17,
    parameter int DEN_W = 32,
    parameter int SHIFT = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [NUM_W-1:0]         i_num,
    input  logic [DEN_W-1:0]         i_den,
    output logic                     o_done,
    output logic [NUM_W+SHIFT-1:0]   o_quot
);
    localparam int DVD_W = NUM_W + SHIFT;
    localparam int CNT_W = $clog2(DVD_W);

    logic [DVD_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             qbit;

    // One restoring step: bring down the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // The quotient bits shift into the dividend register from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num, {SHIFT{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], qbit};
            r_rem <= qbit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

// ===== rtl/vrt_datapath.sv =====
module vrt_datapath #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vrt_pkg::t_cmd                       i_cmd,
    output vrt_pkg::t_sts                       o_sts,
    input  logic [vrt_pkg::ID_W-1:0]            i_pass_a,
    input  logic [vrt_pkg::ID_W-1:0]            i_pass_b,
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_origin [3],
    input  logic signed [vrt_pkg::DIR_W-1:0]    i_dir [3],
    input  logic [vrt_pkg::ID_W-1:0]            i_block_id,
    output logic [vrt_pkg::STAT_W-1:0]          o_status,
    output logic signed [vrt_pkg::VOX_W-1:0]    o_voxel [3],
    output logic signed [vrt_pkg::FACE_W-1:0]   o_face [3]
);
    import vrt_pkg::*;

    localparam int NUM_W = FRAC_BITS + 1;
    localparam int QT_W  = NUM_W + T_FRAC;
    localparam int QX_W  = (QT_W > T_W) ? QT_W : T_W;
    localparam logic [NUM_W-1:0] ONE_FX = NUM_W'(1) << FRAC_BITS;

    // Ray state.
    logic [COORD_BITS-1:0] r_cell [3];
    logic [1:0]            r_sign [3];
    logic [T_W-1:0]        r_next [3];
    logic [T_W-1:0]        r_spc  [3];
    logic [1:0]            r_face [3];
    logic                  r_neg  [3];
    logic [DIR_W-1:0]      r_mag  [3];
    logic [FRAC_BITS-1:0]  r_frac [3];
    logic [1:0]            r_ax;
    logic                  r_active;

    // Result register.
    logic [STAT_W-1:0]        r_status;
    logic signed [VOX_W-1:0]  r_voxel [3];
    logic signed [FACE_W-1:0] r_face_out [3];

    logic [DIR_W-1:0]      mag        [3];
    logic [COORD_BITS-1:0] start_cell [3];
    logic signed [63:0]    ox         [3];
    logic [NUM_W-1:0]      num;
    logic [DIR_W-1:0]      den;
    logic                  div_done;
    logic [QT_W-1:0]       quot;
    logic [QX_W-1:0]       quot_x;
    logic [T_W-1:0]        quot_sat;
    logic [1:0]            ax;
    logic [T_W:0]          sum;
    logic [T_W-1:0]        sum_sat;
    logic                  solid;

    // Start set-up: cell is the floor of the origin, magnitude of each direction.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag[a]        = i_dir[a][DIR_W-1] ? DIR_W'(-i_dir[a]) : DIR_W'(i_dir[a]);
            ox[a]         = 64'(i_origin[a]) >>> FRAC_BITS;
            start_cell[a] = ox[a][COORD_BITS-1:0];
        end
    end

    // Divider operands for the current job, and saturation of its quotient.
    always_comb begin
        if (i_cmd.kind == KIND_SPACING) begin
            num = ONE_FX;
        end else if (r_neg[i_cmd.axis]) begin
            num = {1'b0, r_frac[i_cmd.axis]};
        end else begin
            num = ONE_FX - {1'b0, r_frac[i_cmd.axis]};
        end
        den      = r_mag[i_cmd.axis];
        quot_x   = QX_W'(quot);
        quot_sat = (quot_x > QX_W'(T_MAX)) ? T_MAX : quot[T_W-1:0];
    end

    vrt_div #(
        .NUM_W (NUM_W),
        .DEN_W (DIR_W),
        .SHIFT (T_FRAC)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // Axis choice: smallest boundary distance, ties to Z, then Y over X.
    always_comb begin
        if (r_next[0] < r_next[1]) begin
            ax = (r_next[0] < r_next[2]) ? 2'd0 : 2'd2;
        end else begin
            ax = (r_next[1] < r_next[2]) ? 2'd1 : 2'd2;
        end
        sum     = {1'b0, r_next[r_ax]} + {1'b0, r_spc[r_ax]};
        sum_sat = sum[T_W] ? T_MAX : sum[T_W-1:0];
        solid   = (i_block_id != '0) && (i_block_id != i_pass_a) && (i_block_id != i_pass_b);
    end

    assign o_sts = '{
        active:   r_active,
        solid:    solid,
        beyond:   (r_next[r_ax] > T_LIMIT),
        div_done: div_done
    };

    // Ray active flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.start_load) begin
            r_active <= 1'b1;
        end else if (i_cmd.clear_active) begin
            r_active <= 1'b0;
        end
    end

    // Per-axis state updates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_load) begin
            for (int a = 0; a < 3; a++) begin
                r_cell[a] <= start_cell[a];
                r_neg[a]  <= i_dir[a][DIR_W-1];
                r_mag[a]  <= mag[a];
                r_frac[a] <= i_origin[a][FRAC_BITS-1:0];
                r_face[a] <= 2'b00;
                if (mag[a] == '0) begin
                    r_sign[a] <= 2'b00;
                end else if (i_dir[a][DIR_W-1]) begin
                    r_sign[a] <= 2'b11;
                end else begin
                    r_sign[a] <= 2'b01;
                end
            end
        end
        if (i_cmd.div_store) begin
            if (i_cmd.kind == KIND_SPACING) begin
                r_spc[i_cmd.axis] <= quot_sat;
            end else begin
                r_next[i_cmd.axis] <= quot_sat;
            end
        end
        if (i_cmd.sel) begin
            r_ax <= ax;
        end
        if (i_cmd.advance) begin
            r_cell[r_ax] <= r_cell[r_ax] + {{(COORD_BITS-2){r_sign[r_ax][1]}}, r_sign[r_ax]};
            r_next[r_ax] <= sum_sat;
            for (int a = 0; a < 3; a++) begin
                r_face[a] <= (2'(a) == r_ax) ? 2'(2'b00 - r_sign[r_ax]) : 2'b00;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= i_cmd.out_status;
            for (int a = 0; a < 3; a++) begin
                case (i_cmd.out_status)
                    ST_QUERY: begin
                        r_voxel[a]    <= VOX_W'(r_cell[a]);
                        r_face_out[a] <= '0;
                    end
                    ST_HIT: begin
                        r_voxel[a]    <= VOX_W'(r_cell[a]);
                        r_face_out[a] <= r_face[a];
                    end
                    default: begin
                        r_voxel[a]    <= '0;
                        r_face_out[a] <= '0;
                    end
                endcase
            end
        end
    end

    assign o_status = r_status;
    assign o_voxel  = r_voxel;
    assign o_face   = r_face_out;

endmodule

// ===== rtl/vrt_ctrl.sv =====
module vrt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_action,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  vrt_pkg::t_sts i_sts,
    output vrt_pkg::t_cmd o_cmd
);
    import vrt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DIV_GO   = 5'b00010,
        S_DIV_WAIT = 5'b00100,
        S_ADV      = 5'b01000,
        S_WRITE    = 5'b10000
    } t_state;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    t_state            r_state, n_state;
    logic [STAT_W-1:0] r_status, n_status;
    logic [1:0]        r_axis, n_axis;
    logic              r_kind, n_kind;
    logic              r_ovalid, n_ovalid;
    logic              accept;
    t_cmd              cmd;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // Sequencer.
    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        n_status = r_status;
        n_axis   = r_axis;
        n_kind   = r_kind;
        cmd.axis = r_axis;
        cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_START) begin
                        cmd.start_load = 1'b1;
                        n_axis         = 2'd0;
                        n_kind         = KIND_NEXT;
                        n_state        = S_DIV_GO;
                    end else if (!i_sts.active) begin
                        n_status = ST_MISS;
                        n_state  = S_WRITE;
                    end else if (i_sts.solid) begin
                        cmd.clear_active = 1'b1;
                        n_status         = ST_HIT;
                        n_state          = S_WRITE;
                    end else begin
                        cmd.sel = 1'b1;
                        n_state = S_ADV;
                    end
                end
            end
            S_DIV_GO: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    cmd.div_store = 1'b1;
                    if (r_axis == AXIS_LAST && r_kind == KIND_SPACING) begin
                        n_status = ST_QUERY;
                        n_state  = S_WRITE;
                    end else begin
                        n_kind  = ~r_kind;
                        n_axis  = (r_kind == KIND_SPACING) ? r_axis + 2'd1 : r_axis;
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_ADV: begin
                if (i_sts.beyond) begin
                    cmd.clear_active = 1'b1;
                    n_status         = ST_MISS;
                end else begin
                    cmd.advance = 1'b1;
                    n_status    = ST_QUERY;
                end
                n_state = S_WRITE;
            end
            S_WRITE: begin
                if (!r_ovalid || !i_out_stall) begin
                    cmd.load_out   = 1'b1;
                    cmd.out_status = r_status;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid flag.
    always_comb begin
        if (cmd.load_out) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_status <= ST_MISS;
            r_axis   <= 2'd0;
            r_kind   <= KIND_NEXT;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_status <= n_status;
            r_axis   <= n_axis;
            r_kind   <= n_kind;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd       = cmd;

endmodule
